FILE: src/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg: shared definitions of the three-component vector unit
// Opcode encoding and status codes of the result beat.
// ----------------------------------------------------------------------------
package v3a_pkg;

	typedef enum logic [3:0] {
		CMD_ADD   = 4'd0,
		CMD_SUB   = 4'd1,
		CMD_SCALE = 4'd2,
		CMD_DIVS  = 4'd3,
		CMD_DOT   = 4'd4,
		CMD_CROSS = 4'd5,
		CMD_COS   = 4'd6,
		CMD_NORM  = 4'd7,
		CMD_MAG   = 4'd8,
		CMD_MAGSQ = 4'd9,
		CMD_NEG   = 4'd10,
		CMD_ABS   = 4'd11
	} cmd_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

endpackage

FILE: src/v3a_sqrt_cell.sv
// ----------------------------------------------------------------------------
// v3a_sqrt_cell: one digit of a restoring square root chain
// Retires one root bit per lane and hands the partial state to the next cell.
// ----------------------------------------------------------------------------
module v3a_sqrt_cell #(
	parameter int W   = 32,
	parameter int NL  = 2,
	parameter int PLW = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [NL-1:0][2*W-1:0]        in_x,
	input  logic [NL-1:0][W+1:0]          in_rem,
	input  logic [NL-1:0][W-1:0]          in_root,
	input  logic [PLW-1:0]                in_pl,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [NL-1:0][2*W-1:0]        out_x,
	output logic [NL-1:0][W+1:0]          out_rem,
	output logic [NL-1:0][W-1:0]          out_root,
	output logic [PLW-1:0]                out_pl
);

	logic                   v_q;
	logic [NL-1:0][2*W-1:0] x_q;
	logic [NL-1:0][W+1:0]   rem_q;
	logic [NL-1:0][W-1:0]   root_q;
	logic [PLW-1:0]         pl_q;

	logic [NL-1:0][W+3:0]   rem2;
	logic [NL-1:0][W+3:0]   trial;
	logic [NL-1:0][W+3:0]   diff;
	logic [NL-1:0]          ge;

	assign in_ready = !v_q || out_ready;

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			rem2[l]  = {in_rem[l], in_x[l][2*W-1:2*W-2]};
			trial[l] = {2'b00, in_root[l], 2'b01};
			diff[l]  = rem2[l] - trial[l];
			ge[l]    = rem2[l] >= trial[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			for (int l = 0; l < NL; l++) begin
				x_q[l]    <= {in_x[l][2*W-3:0], 2'b00};
				rem_q[l]  <= ge[l] ? diff[l][W+1:0] : rem2[l][W+1:0];
				root_q[l] <= {in_root[l][W-2:0], ge[l]};
			end
			pl_q <= in_pl;
		end
	end

	assign out_valid = v_q;
	assign out_x     = x_q;
	assign out_rem   = rem_q;
	assign out_root  = root_q;
	assign out_pl    = pl_q;

endmodule

FILE: src/v3a_div_cell.sv
// ----------------------------------------------------------------------------
// v3a_div_cell: one quotient bit of a restoring divider chain
// Shifts in one dividend bit per lane, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module v3a_div_cell #(
	parameter int W   = 32,
	parameter int DD  = 64,
	parameter int NL  = 3,
	parameter int PLW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [NL-1:0][DD-1:0]  in_rem,
	input  logic [NL-1:0][W-1:0]   in_nlo,
	input  logic [NL-1:0][W-1:0]   in_q,
	input  logic [NL-1:0][DD-1:0]  in_d,
	input  logic [PLW-1:0]         in_pl,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [NL-1:0][DD-1:0]  out_rem,
	output logic [NL-1:0][W-1:0]   out_nlo,
	output logic [NL-1:0][W-1:0]   out_q,
	output logic [NL-1:0][DD-1:0]  out_d,
	output logic [PLW-1:0]         out_pl
);

	logic                  v_q;
	logic [NL-1:0][DD-1:0] rem_q;
	logic [NL-1:0][W-1:0]  nlo_q;
	logic [NL-1:0][W-1:0]  q_q;
	logic [NL-1:0][DD-1:0] d_q;
	logic [PLW-1:0]        pl_q;

	logic [NL-1:0][DD:0]   r2;
	logic [NL-1:0][DD:0]   diff;
	logic [NL-1:0]         ge;

	assign in_ready = !v_q || out_ready;

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			r2[l]   = {in_rem[l], in_nlo[l][W-1]};
			diff[l] = r2[l] - {1'b0, in_d[l]};
			ge[l]   = r2[l] >= {1'b0, in_d[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			for (int l = 0; l < NL; l++) begin
				rem_q[l] <= ge[l] ? diff[l][DD-1:0] : r2[l][DD-1:0];
				nlo_q[l] <= {in_nlo[l][W-2:0], 1'b0};
				q_q[l]   <= {in_q[l][W-2:0], ge[l]};
				d_q[l]   <= in_d[l];
			end
			pl_q <= in_pl;
		end
	end

	assign out_valid = v_q;
	assign out_rem   = rem_q;
	assign out_nlo   = nlo_q;
	assign out_q     = q_q;
	assign out_d     = d_q;
	assign out_pl    = pl_q;

endmodule

FILE: src/vec3_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// vec3_arithmetic_unit: pipelined three-component fixed-point vector ALU
// throughput: one command beat per cycle while res_ready does not stall the output;
// the cell chains set it, retiring one root bit or one quotient bit per cell per cycle
// every operation takes the full chain, so results leave in order
// reset: arst_n clears all stage valids; datapath registers are not reset
// ----------------------------------------------------------------------------
module vec3_arithmetic_unit
	import v3a_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [3:0]                  command,
	input  logic signed [WORD_BITS-1:0] a_x,
	input  logic signed [WORD_BITS-1:0] a_y,
	input  logic signed [WORD_BITS-1:0] a_z,
	input  logic signed [WORD_BITS-1:0] b_x,
	input  logic signed [WORD_BITS-1:0] b_y,
	input  logic signed [WORD_BITS-1:0] b_z,
	input  logic signed [WORD_BITS-1:0] scale_value,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic signed [WORD_BITS-1:0] r_x,
	output logic signed [WORD_BITS-1:0] r_y,
	output logic signed [WORD_BITS-1:0] r_z,
	output logic signed [WORD_BITS-1:0] r_scalar,
	output logic [1:0]                  status
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int RW = 2*W+2;            // exact sum of three products
	localparam int DD = 2*W;              // divisor width (product of magnitudes)
	localparam int NW = 2*W+F;            // widest shifted dividend
	localparam int CW = (W+F > 2*W) ? W+F : 2*W;

	// context that rides along the chains
	typedef struct packed {
		logic [3:0]         cmd;
		logic [2:0][W-1:0]  a;
		logic [W-1:0]       s;
		logic [RW-1:0]      dotab;
		logic               aa_zero;
		logic [2:0][W-1:0]  rv;
		logic [W-1:0]       rs;
		logic               ovf;
		logic               div0;
		logic [2:0]         qneg;
		logic [2:0]         qovf;
	} ctx_t;

	localparam int PLW = $bits(ctx_t);

	// sign extend a word into the wide raw format
	function automatic logic signed [RW-1:0] sx(input logic [W-1:0] v);
		sx = {{(RW-W){v[W-1]}}, v};
	endfunction

	// sign extend a product into the wide raw format
	function automatic logic signed [RW-1:0] sx2(input logic [2*W-1:0] v);
		sx2 = {{2{v[2*W-1]}}, v};
	endfunction

	// saturate a wide value to a word, overflow flag on top
	function automatic logic [W:0] sat(input logic [RW-1:0] v);
		logic           same;
		logic [W-1:0]   val;
		same = (&v[RW-1:W-1]) || !(|v[RW-1:W-1]);
		if (same) begin
			val = v[W-1:0];
		end else if (v[RW-1]) begin
			val = {1'b1, {(W-1){1'b0}}};
		end else begin
			val = {1'b0, {(W-1){1'b1}}};
		end
		return {!same, val};
	endfunction

	// magnitude of a word, as an unsigned word
	function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
		logic [W-1:0] n;
		n = ~v + 1'b1;
		return v[W-1] ? n : v;
	endfunction

	// apply the sign to a quotient magnitude and saturate it
	function automatic logic [W:0] qsat(input logic [W-1:0] q, input logic ng,
			input logic ov);
		logic [W:0]   v;
		logic         big;
		logic [W-1:0] val;
		v = {1'b0, q};
		if (ng) begin
			v = ~v + 1'b1;
		end
		big = ov || (v[W] != v[W-1]);
		if (!big) begin
			val = v[W-1:0];
		end else if (ng) begin
			val = {1'b1, {(W-1){1'b0}}};
		end else begin
			val = {1'b0, {(W-1){1'b1}}};
		end
		return {big, val};
	endfunction

	// ---------------- stage 1: all products ----------------
	logic signed [W-1:0] av [3];
	logic signed [W-1:0] bv [3];

	assign av[0] = a_x;
	assign av[1] = a_y;
	assign av[2] = a_z;
	assign bv[0] = b_x;
	assign bv[1] = b_y;
	assign bv[2] = b_z;

	logic                  v_s1;
	logic                  rdy_s1;
	logic [3:0]            cmd_s1;
	logic [W-1:0]          a_s1 [3];
	logic [W-1:0]          b_s1 [3];
	logic [W-1:0]          s_s1;
	logic signed [2*W-1:0] pab_s1 [3];
	logic signed [2*W-1:0] paa_s1 [3];
	logic signed [2*W-1:0] pbb_s1 [3];
	logic signed [2*W-1:0] pas_s1 [3];
	logic signed [2*W-1:0] xp_s1 [6];

	logic                  v_s2;
	logic                  rdy_s2;

	assign rdy_s1    = !v_s1 || rdy_s2;
	assign cmd_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && cmd_valid) begin
			cmd_s1 <= command;
			s_s1   <= scale_value;
			for (int i = 0; i < 3; i++) begin
				a_s1[i]   <= av[i];
				b_s1[i]   <= bv[i];
				pab_s1[i] <= av[i] * bv[i];
				paa_s1[i] <= av[i] * av[i];
				pbb_s1[i] <= bv[i] * bv[i];
				pas_s1[i] <= av[i] * scale_value;
			end
			// cross terms: x = yz - zy, y = zx - xz, z = xy - yx
			xp_s1[0] <= av[1] * bv[2];
			xp_s1[1] <= av[2] * bv[1];
			xp_s1[2] <= av[2] * bv[0];
			xp_s1[3] <= av[0] * bv[2];
			xp_s1[4] <= av[0] * bv[1];
			xp_s1[5] <= av[1] * bv[0];
		end
	end

	// ---------------- stage 2: sums and direct results ----------------
	logic signed [RW-1:0] dab_c;
	logic [2*W-1:0]       daa_c;
	logic [2*W-1:0]       dbb_c;
	logic signed [RW-1:0] tmp_c;
	logic signed [RW-1:0] raw_v [3];
	logic signed [RW-1:0] raw_s;
	logic [W:0]           st2;
	ctx_t                 c2;

	always_comb begin
		dab_c = sx2(pab_s1[0]) + sx2(pab_s1[1]) + sx2(pab_s1[2]);
		daa_c = paa_s1[0] + paa_s1[1] + paa_s1[2];
		dbb_c = pbb_s1[0] + pbb_s1[1] + pbb_s1[2];
		tmp_c = '0;
		raw_s = '0;
		for (int i = 0; i < 3; i++) begin
			raw_v[i] = '0;
		end
		case (cmd_s1)
			CMD_ADD: begin
				for (int i = 0; i < 3; i++) raw_v[i] = sx(a_s1[i]) + sx(b_s1[i]);
			end
			CMD_SUB: begin
				for (int i = 0; i < 3; i++) raw_v[i] = sx(a_s1[i]) - sx(b_s1[i]);
			end
			CMD_SCALE: begin
				for (int i = 0; i < 3; i++) raw_v[i] = sx2(pas_s1[i]) >>> F;
			end
			CMD_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					tmp_c    = sx2(xp_s1[2*i]) - sx2(xp_s1[2*i+1]);
					raw_v[i] = tmp_c >>> F;
				end
			end
			CMD_DOT: begin
				raw_s = dab_c >>> F;
			end
			CMD_MAGSQ: begin
				tmp_c = {2'b00, daa_c};
				raw_s = tmp_c >>> F;
			end
			CMD_NEG: begin
				for (int i = 0; i < 3; i++) raw_v[i] = -sx(a_s1[i]);
			end
			CMD_ABS: begin
				for (int i = 0; i < 3; i++) begin
					raw_v[i] = a_s1[i][W-1] ? -sx(a_s1[i]) : sx(a_s1[i]);
				end
			end
			default: begin
			end
		endcase

		c2         = '0;
		c2.cmd     = cmd_s1;
		c2.s       = s_s1;
		c2.dotab   = dab_c;
		c2.aa_zero = (daa_c == '0);
		for (int i = 0; i < 3; i++) begin
			c2.a[i]  = a_s1[i];
			st2      = sat(raw_v[i]);
			c2.rv[i] = st2[W-1:0];
			c2.ovf   = c2.ovf | st2[W];
		end
		st2    = sat(raw_s);
		c2.rs  = st2[W-1:0];
		c2.ovf = c2.ovf | st2[W];
	end

	ctx_t           ctx_s2;
	logic [2*W-1:0] daa_s2;
	logic [2*W-1:0] dbb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			ctx_s2 <= c2;
			daa_s2 <= daa_c;
			dbb_s2 <= dbb_c;
		end
	end

	// ---------------- square root chain: |a| in lane 0, |b| in lane 1 ----------------
	logic [W:0]                 sq_v;
	logic [W:0]                 sq_r;
	logic [W:0][1:0][2*W-1:0]   sq_x;
	logic [W:0][1:0][W+1:0]     sq_rem;
	logic [W:0][1:0][W-1:0]     sq_root;
	logic [W:0][PLW-1:0]        sq_pl;

	logic                       v_s3;
	logic                       rdy_s3;

	assign sq_v[0]    = v_s2;
	assign sq_x[0]    = {dbb_s2, daa_s2};
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_pl[0]   = ctx_s2;
	assign rdy_s2     = !v_s2 || sq_r[0];
	assign sq_r[W]    = rdy_s3;

	for (genvar k = 0; k < W; k++) begin : g_sq
		v3a_sqrt_cell #(
			.W   (W),
			.NL  (2),
			.PLW (PLW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sq_v[k]),
			.in_ready  (sq_r[k]),
			.in_x      (sq_x[k]),
			.in_rem    (sq_rem[k]),
			.in_root   (sq_root[k]),
			.in_pl     (sq_pl[k]),
			.out_valid (sq_v[k+1]),
			.out_ready (sq_r[k+1]),
			.out_x     (sq_x[k+1]),
			.out_rem   (sq_rem[k+1]),
			.out_root  (sq_root[k+1]),
			.out_pl    (sq_pl[k+1])
		);
	end

	// ---------------- stage 3: product of magnitudes ----------------
	ctx_t           ctx_s3;
	logic [W-1:0]   ma_s3;
	logic [W-1:0]   mb_s3;
	logic [2*W-1:0] mab_s3;

	logic           v_s4;
	logic           rdy_s4;

	assign rdy_s3 = !v_s3 || rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= sq_v[W];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && sq_v[W]) begin
			ctx_s3 <= ctx_t'(sq_pl[W]);
			ma_s3  <= sq_root[W][0];
			mb_s3  <= sq_root[W][1];
			mab_s3 <= sq_root[W][0] * sq_root[W][1];
		end
	end

	// ---------------- stage 4: divider setup ----------------
	logic [NW-1:0]          n_c [3];
	logic [DD-1:0]          d_c [3];
	logic [CW-1:0]          hi_c;
	logic [RW-1:0]          dmag_c;
	logic [W:0]             st4;
	logic [2:0][DD-1:0]     rem_c;
	logic [2:0][W-1:0]      nlo_c;
	logic [2:0][DD-1:0]     dd_c;
	ctx_t                   c4;

	always_comb begin
		c4     = ctx_s3;
		c4.div0 = 1'b0;
		c4.qneg = '0;
		c4.qovf = '0;
		dmag_c = '0;
		st4    = '0;
		hi_c   = '0;
		for (int i = 0; i < 3; i++) begin
			n_c[i] = '0;
			d_c[i] = '0;
		end
		case (ctx_s3.cmd)
			CMD_DIVS: begin
				c4.div0 = (ctx_s3.s == '0);
				for (int i = 0; i < 3; i++) begin
					n_c[i]     = NW'(mag_w(ctx_s3.a[i])) << F;
					d_c[i]     = DD'(mag_w(ctx_s3.s));
					c4.qneg[i] = ctx_s3.a[i][W-1] ^ ctx_s3.s[W-1];
				end
			end
			CMD_NORM: begin
				// zero vector passes unchanged
				if (ctx_s3.aa_zero) begin
					c4.rv = ctx_s3.a;
				end
				for (int i = 0; i < 3; i++) begin
					n_c[i]     = NW'(mag_w(ctx_s3.a[i])) << F;
					d_c[i]     = DD'(ma_s3);
					c4.qneg[i] = ctx_s3.a[i][W-1];
				end
			end
			CMD_COS: begin
				c4.div0    = (ma_s3 == '0) || (mb_s3 == '0);
				dmag_c     = ctx_s3.dotab[RW-1] ? -ctx_s3.dotab : ctx_s3.dotab;
				n_c[0]     = NW'(dmag_c[2*W-1:0]) << F;
				d_c[0]     = mab_s3;
				c4.qneg[0] = ctx_s3.dotab[RW-1];
			end
			CMD_MAG: begin
				st4    = sat(RW'(ma_s3));
				c4.rs  = st4[W-1:0];
				c4.ovf = st4[W];
			end
			default: begin
			end
		endcase
		// the quotient must fit W bits: flag it when the upper dividend part
		// already holds the divisor
		for (int i = 0; i < 3; i++) begin
			hi_c       = CW'(n_c[i][NW-1:W]);
			c4.qovf[i] = hi_c >= CW'(d_c[i]);
			rem_c[i]   = hi_c[DD-1:0];
			nlo_c[i]   = n_c[i][W-1:0];
			dd_c[i]    = d_c[i];
		end
	end

	ctx_t               ctx_s4;
	logic [2:0][DD-1:0] rem_s4;
	logic [2:0][W-1:0]  nlo_s4;
	logic [2:0][DD-1:0] d_s4;

	logic [W:0]               dv_v;
	logic [W:0]               dv_r;
	logic [W:0][2:0][DD-1:0]  dv_rem;
	logic [W:0][2:0][W-1:0]   dv_nlo;
	logic [W:0][2:0][W-1:0]   dv_q;
	logic [W:0][2:0][DD-1:0]  dv_d;
	logic [W:0][PLW-1:0]      dv_pl;

	assign rdy_s4 = !v_s4 || dv_r[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			ctx_s4 <= c4;
			rem_s4 <= rem_c;
			nlo_s4 <= nlo_c;
			d_s4   <= dd_c;
		end
	end

	// ---------------- divider chain: one quotient bit per cell ----------------
	logic rdy_o;

	assign dv_v[0]   = v_s4;
	assign dv_rem[0] = rem_s4;
	assign dv_nlo[0] = nlo_s4;
	assign dv_q[0]   = '0;
	assign dv_d[0]   = d_s4;
	assign dv_pl[0]  = ctx_s4;
	assign dv_r[W]   = rdy_o;

	for (genvar k = 0; k < W; k++) begin : g_dv
		v3a_div_cell #(
			.W   (W),
			.DD  (DD),
			.NL  (3),
			.PLW (PLW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_v[k]),
			.in_ready  (dv_r[k]),
			.in_rem    (dv_rem[k]),
			.in_nlo    (dv_nlo[k]),
			.in_q      (dv_q[k]),
			.in_d      (dv_d[k]),
			.in_pl     (dv_pl[k]),
			.out_valid (dv_v[k+1]),
			.out_ready (dv_r[k+1]),
			.out_rem   (dv_rem[k+1]),
			.out_nlo   (dv_nlo[k+1]),
			.out_q     (dv_q[k+1]),
			.out_d     (dv_d[k+1]),
			.out_pl    (dv_pl[k+1])
		);
	end

	// ---------------- output register: quotient sign, saturation, status ----------------
	ctx_t              cf;
	logic [2:0][W-1:0] fx;
	logic [W-1:0]      fs;
	logic              fo;
	logic [1:0]        fst;
	logic [W:0]        stf;

	always_comb begin
		cf  = ctx_t'(dv_pl[W]);
		fx  = cf.rv;
		fs  = cf.rs;
		fo  = cf.ovf;
		stf = '0;
		if ((cf.cmd == CMD_DIVS && !cf.div0) || (cf.cmd == CMD_NORM && !cf.aa_zero)) begin
			for (int i = 0; i < 3; i++) begin
				stf   = qsat(dv_q[W][i], cf.qneg[i], cf.qovf[i]);
				fx[i] = stf[W-1:0];
				fo    = fo | stf[W];
			end
		end
		if (cf.cmd == CMD_COS && !cf.div0) begin
			stf = qsat(dv_q[W][0], cf.qneg[0], cf.qovf[0]);
			fs  = stf[W-1:0];
			fo  = fo | stf[W];
		end
		if (cf.div0) begin
			fst = ST_DIV0;
		end else if (fo) begin
			fst = ST_OVF;
		end else begin
			fst = ST_OK;
		end
	end

	// result beat waits here until res_ready; the chains stall behind it as they fill
	assign rdy_o = !res_valid || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (rdy_o) begin
			res_valid <= dv_v[W];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && dv_v[W]) begin
			r_x      <= fx[0];
			r_y      <= fx[1];
			r_z      <= fx[2];
			r_scalar <= fs;
			status   <= fst;
		end
	end

endmodule
